### rtl/stifc_pkg.sv
// ----------------------------------------------------------------------------
// stifc_pkg
// Shared types and constants for the sorted table insert/find/count unit.
// ----------------------------------------------------------------------------
package stifc_pkg;

  // Operation codes carried on the input word.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_FIND   = 2'd1;
  localparam logic [1:0] OP_COUNT  = 2'd2;

  // Field widths of the result word.
  localparam int unsigned POS_W   = 8;
  localparam int unsigned MATCH_W = 9;
  localparam int unsigned VALUE_W = 32;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_SCAN_RD,
    ST_SCAN_CMP
  } state_t;

  // Table read address, relative to the datapath index register.
  typedef enum logic [1:0] {
    RA_IDX,
    RA_IDX_M1,
    RA_IDX_M2,
    RA_IDX_P1
  } rd_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;       // latch opcode and value, set up index
    logic    rd_en;      // read one table entry
    rd_sel_t rd_sel;     // which entry to read
    logic    idx_inc;    // step the index up
    logic    idx_dec;    // step the index down
    logic    wr_shift;   // move the entry just read one slot up
    logic    wr_key;     // store the value at the index
    logic    cnt_inc;    // one more entry in the table
    logic    match_inc;  // the entry just read equals the value
    logic    respond;    // emit the result word
    logic    hit;        // find located the value at the index
    logic    match_out;  // result carries the match count
    logic    refuse;     // insert refused, table full
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;      // table holds its capacity
    logic empty;     // table holds nothing
    logic op_find;   // latched opcode is find
    logic rd_gt;     // entry read is greater than the value
    logic rd_eq;     // entry read equals the value
    logic idx_zero;  // index is zero
    logic idx_one;   // index is one
    logic last;      // index addresses the last valid entry
  } dp_stat_t;

endpackage

### rtl/stifc_dp.sv
// ----------------------------------------------------------------------------
// stifc_dp
// Datapath: table memory, index and counters, compare logic, result register.
// ----------------------------------------------------------------------------
module stifc_dp #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  stifc_pkg::ctl_cmd_t                cmd,
  output stifc_pkg::dp_stat_t                stat,
  input  logic [1:0]                         in_opcode,
  input  logic signed [stifc_pkg::VALUE_W-1:0] in_value,
  output logic                               out_valid,
  output logic                               out_found,
  output logic [stifc_pkg::POS_W-1:0]        out_position,
  output logic [stifc_pkg::MATCH_W-1:0]      out_match_count,
  output logic                               out_status
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned PEXT_W = (IDX_W > stifc_pkg::POS_W) ? IDX_W : stifc_pkg::POS_W;
  localparam int unsigned MEXT_W = (CNT_W > stifc_pkg::MATCH_W) ? CNT_W : stifc_pkg::MATCH_W;

  logic signed [stifc_pkg::VALUE_W-1:0] mem [CAPACITY];

  logic [1:0]                         op_r;
  logic signed [stifc_pkg::VALUE_W-1:0] key_r;
  logic signed [stifc_pkg::VALUE_W-1:0] rdata_r;
  logic [IDX_W-1:0]                   idx_r;
  logic [CNT_W-1:0]                   count_r;
  logic [CNT_W-1:0]                   match_r;
  logic [IDX_W-1:0]                   rd_addr;
  logic [CNT_W-1:0]                   match_sum;
  logic [PEXT_W-1:0]                  pos_ext;
  logic [MEXT_W-1:0]                  match_ext;

  logic                               out_valid_r;
  logic                               out_found_r;
  logic [stifc_pkg::POS_W-1:0]        out_position_r;
  logic [stifc_pkg::MATCH_W-1:0]      out_match_r;
  logic                               out_status_r;

  always_comb begin
    case (cmd.rd_sel)
      stifc_pkg::RA_IDX_M1: rd_addr = idx_r - IDX_W'(1);
      stifc_pkg::RA_IDX_M2: rd_addr = idx_r - IDX_W'(2);
      stifc_pkg::RA_IDX_P1: rd_addr = idx_r + IDX_W'(1);
      default:              rd_addr = idx_r;
    endcase
  end

  // Single-port style table: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.wr_shift) begin
      mem[idx_r] <= rdata_r;
    end else if (cmd.wr_key) begin
      mem[idx_r] <= key_r;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_opcode;
      key_r <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      count_r <= '0;
      match_r <= '0;
    end else begin
      if (cmd.load) begin
        idx_r   <= (in_opcode == stifc_pkg::OP_INSERT) ? count_r[IDX_W-1:0] : '0;
        match_r <= '0;
      end else begin
        if (cmd.idx_inc) begin
          idx_r <= idx_r + IDX_W'(1);
        end else if (cmd.idx_dec) begin
          idx_r <= idx_r - IDX_W'(1);
        end
        if (cmd.match_inc) begin
          match_r <= match_r + CNT_W'(1);
        end
      end
      if (cmd.cnt_inc) begin
        count_r <= count_r + CNT_W'(1);
      end
    end
  end

  assign match_sum = match_r + (cmd.match_inc ? CNT_W'(1) : CNT_W'(0));
  assign pos_ext   = PEXT_W'(idx_r);
  assign match_ext = MEXT_W'(match_sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.respond;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      out_found_r    <= cmd.hit;
      out_position_r <= cmd.hit ? pos_ext[stifc_pkg::POS_W-1:0] : '0;
      out_match_r    <= cmd.match_out ? match_ext[stifc_pkg::MATCH_W-1:0] : '0;
      out_status_r   <= cmd.refuse;
    end
  end

  assign stat.full     = (count_r == CNT_W'(CAPACITY));
  assign stat.empty    = (count_r == '0);
  assign stat.op_find  = (op_r == stifc_pkg::OP_FIND);
  assign stat.rd_gt    = (rdata_r > key_r);
  assign stat.rd_eq    = (rdata_r == key_r);
  assign stat.idx_zero = (idx_r == '0);
  assign stat.idx_one  = (idx_r == IDX_W'(1));
  assign stat.last     = ((CNT_W'(idx_r) + CNT_W'(1)) >= count_r);

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_position    = out_position_r;
  assign out_match_count = out_match_r;
  assign out_status      = out_status_r;

endmodule

### rtl/stifc_ctrl.sv
// ----------------------------------------------------------------------------
// stifc_ctrl
// Controller: sequences the shift-insert and the linear scan over the table.
// ----------------------------------------------------------------------------
module stifc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [1:0]          in_opcode,
  input  stifc_pkg::dp_stat_t stat,
  output stifc_pkg::ctl_cmd_t cmd,
  output logic                busy
);

  stifc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= stifc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd.load      = 1'b0;
    cmd.rd_en     = 1'b0;
    cmd.rd_sel    = stifc_pkg::RA_IDX;
    cmd.idx_inc   = 1'b0;
    cmd.idx_dec   = 1'b0;
    cmd.wr_shift  = 1'b0;
    cmd.wr_key    = 1'b0;
    cmd.cnt_inc   = 1'b0;
    cmd.match_inc = 1'b0;
    cmd.respond   = 1'b0;
    cmd.hit       = 1'b0;
    cmd.match_out = 1'b0;
    cmd.refuse    = 1'b0;

    case (state_r)
      stifc_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          case (in_opcode)
            stifc_pkg::OP_INSERT: begin
              if (stat.full) begin
                cmd.respond = 1'b1;
                cmd.refuse  = 1'b1;
              end else begin
                state_nxt = stifc_pkg::ST_INS_RD;
              end
            end
            stifc_pkg::OP_FIND, stifc_pkg::OP_COUNT: begin
              if (stat.empty) begin
                cmd.respond = 1'b1;
              end else begin
                state_nxt = stifc_pkg::ST_SCAN_RD;
              end
            end
            default: begin
              cmd.respond = 1'b1;
            end
          endcase
        end
      end

      stifc_pkg::ST_INS_RD: begin
        if (stat.idx_zero) begin
          cmd.wr_key  = 1'b1;
          cmd.cnt_inc = 1'b1;
          cmd.respond = 1'b1;
          state_nxt   = stifc_pkg::ST_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = stifc_pkg::RA_IDX_M1;
          state_nxt  = stifc_pkg::ST_INS_CMP;
        end
      end

      stifc_pkg::ST_INS_CMP: begin
        if (stat.rd_gt) begin
          // Larger entry moves up one slot; keep walking down.
          cmd.wr_shift = 1'b1;
          cmd.idx_dec  = 1'b1;
          if (stat.idx_one) begin
            state_nxt = stifc_pkg::ST_INS_RD;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = stifc_pkg::RA_IDX_M2;
          end
        end else begin
          cmd.wr_key  = 1'b1;
          cmd.cnt_inc = 1'b1;
          cmd.respond = 1'b1;
          state_nxt   = stifc_pkg::ST_IDLE;
        end
      end

      stifc_pkg::ST_SCAN_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = stifc_pkg::RA_IDX;
        state_nxt  = stifc_pkg::ST_SCAN_CMP;
      end

      stifc_pkg::ST_SCAN_CMP: begin
        if (stat.op_find) begin
          if (stat.rd_eq) begin
            cmd.hit     = 1'b1;
            cmd.respond = 1'b1;
            state_nxt   = stifc_pkg::ST_IDLE;
          end else if (stat.rd_gt || stat.last) begin
            cmd.respond = 1'b1;
            state_nxt   = stifc_pkg::ST_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = stifc_pkg::RA_IDX_P1;
          end
        end else begin
          cmd.match_inc = stat.rd_eq;
          if (stat.last) begin
            cmd.match_out = 1'b1;
            cmd.respond   = 1'b1;
            state_nxt     = stifc_pkg::ST_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = stifc_pkg::RA_IDX_P1;
          end
        end
      end

      default: begin
        state_nxt = stifc_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != stifc_pkg::ST_IDLE);

endmodule

### rtl/sorted_table_insert_find_count_unit.sv
// ----------------------------------------------------------------------------
// sorted_table_insert_find_count_unit
// Bounded table of signed 32-bit values kept in ascending order, with
// duplicates, supporting insert, find-first and count-equal operations.
// ----------------------------------------------------------------------------
//
// Channel   Ports                                        Handshake
// -------   -------------------------------------------  -----------------------
// input     in_opcode, in_value                          start & !busy
// result    out_found, out_position, out_match_count,    out_valid, one cycle,
//           out_status                                   cannot be held off
//
// An insert walks down from the fill level, moving each stored entry greater
// than the value up one slot, then writes the value; an insert into an empty
// table writes it at once. A find compares entries up to the first one that
// is equal or greater (at most the fill level). A count compares every stored
// entry. Busy is high while an operation runs, except in the accepting cycle.
// Refused inserts, operations on an empty table and the unused opcode finish
// in the accepting cycle. The rate is set by the single table memory, which
// moves or reads one entry a cycle.
// The result word appears in the cycle after the operation finishes, and busy
// has already dropped then, so the next word can be started while the result
// is on the output. Synchronous reset empties the table; the stored entries
// themselves are not cleared, since only slots below the fill count are read.
//
module sorted_table_insert_find_count_unit #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_opcode,
  input  logic signed [stifc_pkg::VALUE_W-1:0] in_value,
  output logic                               out_valid,
  output logic                               out_found,
  output logic [stifc_pkg::POS_W-1:0]        out_position,
  output logic [stifc_pkg::MATCH_W-1:0]      out_match_count,
  output logic                               out_status
);

  // Command and status between the sequencer and the datapath.
  stifc_pkg::ctl_cmd_t cmd;
  stifc_pkg::dp_stat_t stat;

  // The sequencer walks the table one entry per cycle: downward while an
  // insert shifts larger entries up, upward while a find or count scans.
  stifc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_opcode (in_opcode),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  // The datapath holds the table memory, the fill count, the scan index,
  // the match counter and the registered result word.
  stifc_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_opcode       (in_opcode),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_found       (out_found),
    .out_position    (out_position),
    .out_match_count (out_match_count),
    .out_status      (out_status)
  );

endmodule

### tb/sv/sorted_table_insert_find_count_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table insert/find/count checker
// Watches the input and result channels of the unit and keeps its own sorted
// copy of the table. It predicts one result word per accepted input word and
// compares each returned word, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module sorted_table_insert_find_count_checker
  import stifc_pkg::*;
#(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  logic [1:0]                 in_opcode,
  input  logic signed [VALUE_W-1:0]  in_value,
  input  logic                       out_valid,
  input  logic                       out_found,
  input  logic [POS_W-1:0]           out_position,
  input  logic [MATCH_W-1:0]         out_match_count,
  input  logic                       out_status,
  output int                         fail_count,
  output int                         replies_owed
);

  typedef struct packed {
    logic               found;
    logic [POS_W-1:0]   position;
    logic [MATCH_W-1:0] match_count;
    logic               status;
  } table_reply_t;

  // Sorted copy of the table; only slots below the fill level are meaningful.
  logic signed [VALUE_W-1:0] sorted_copy [CAPACITY];
  int unsigned               copy_fill;
  table_reply_t              expected_replies [$];
  table_reply_t              oldest;
  int                        bad_now;

  initial begin
    fail_count    = 0;
    replies_owed  = 0;
    copy_fill     = 0;
  end

  // Applies one operation to the sorted copy and returns the word it should yield.
  function automatic table_reply_t apply_table_op(input logic [1:0] op,
                                                  input logic signed [VALUE_W-1:0] key);
    table_reply_t reply;
    int unsigned  slot;
    int unsigned  i;
    int unsigned  equal_seen;
    reply      = '0;
    equal_seen = 0;
    case (op)
      OP_INSERT: begin
        if (copy_fill >= CAPACITY) begin
          reply.status = 1'b1;
        end else begin
          slot = copy_fill;
          while (slot > 0 && sorted_copy[slot-1] > key) begin
            sorted_copy[slot] = sorted_copy[slot-1];
            slot--;
          end
          sorted_copy[slot] = key;
          copy_fill++;
        end
      end
      OP_FIND: begin
        for (i = 0; i < copy_fill; i++) begin
          if (sorted_copy[i] == key) begin
            reply.found    = 1'b1;
            reply.position = POS_W'(i);
            break;
          end
          if (sorted_copy[i] > key) break;
        end
      end
      OP_COUNT: begin
        for (i = 0; i < copy_fill; i++) begin
          if (sorted_copy[i] == key) equal_seen++;
        end
        reply.match_count = MATCH_W'(equal_seen);
      end
      default: begin
      end
    endcase
    return reply;
  endfunction

  function automatic int field_check(input string field, input int unsigned want,
                                     input int unsigned got);
    if (want == got) return 0;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    return 1;
  endfunction

  // Results are retired before the new word is queued, since a word's result can
  // never appear at the edge that accepts it.
  always @(posedge clk) begin
    bad_now = 0;
    if (!rst_n) begin
      copy_fill = 0;
      expected_replies.delete();
    end else begin
      if (out_valid) begin
        if (expected_replies.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual %0d/%0d/%0d/%0d",
                   $time, out_found, out_position, out_match_count, out_status);
          bad_now++;
        end else begin
          oldest  = expected_replies.pop_front();
          bad_now += field_check("found", oldest.found, out_found);
          bad_now += field_check("position", oldest.position, out_position);
          bad_now += field_check("match_count", oldest.match_count, out_match_count);
          bad_now += field_check("status", oldest.status, out_status);
        end
      end
      if (start && !busy) expected_replies.push_back(apply_table_op(in_opcode, in_value));
    end
    fail_count   <= fail_count + bad_now;
    replies_owed <= expected_replies.size();
  end

endmodule

### tb/sv/sorted_table_insert_find_count_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table insert/find/count unit testbench
// Drives directed and random insert, find and count words into the unit, with
// random idle bursts and occasional full drains, and lets a checker beside the
// unit predict and compare every result word. Gives the final verdict.
// ----------------------------------------------------------------------------
module sorted_table_insert_find_count_unit_tb;
  import stifc_pkg::*;

  localparam int unsigned TABLE_DEPTH = 256;
  // Total words to send, and the closing stretch that runs without idling.
  localparam int unsigned WORD_COUNT  = 1700;
  localparam int unsigned CALM_TAIL   = 150;
  // The fourth opcode has no operation behind it; the unit must still answer.
  localparam logic [1:0]  OP_SPARE    = 2'd3;
  localparam logic signed [VALUE_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic [1:0]                in_opcode;
  logic signed [VALUE_W-1:0] in_value;
  logic                      out_valid;
  logic                      out_found;
  logic [POS_W-1:0]          out_position;
  logic [MATCH_W-1:0]        out_match_count;
  logic                      out_status;
  int                        fail_count;
  int                        replies_owed;

  // Keys the unit has actually stored, so that random finds and counts can be
  // aimed at values that are present.
  logic signed [VALUE_W-1:0] stored_keys [$];
  int unsigned               words_sent;

  sorted_table_insert_find_count_unit #(
    .CAPACITY(TABLE_DEPTH)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_found      (out_found),
    .out_position   (out_position),
    .out_match_count(out_match_count),
    .out_status     (out_status)
  );

  sorted_table_insert_find_count_checker #(
    .CAPACITY(TABLE_DEPTH)
  ) CHK (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_found      (out_found),
    .out_position   (out_position),
    .out_match_count(out_match_count),
    .out_status     (out_status),
    .fail_count     (fail_count),
    .replies_owed   (replies_owed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The slowest correct run, about 1700 words that each walk a full table, takes
  // near 5.5 ms; the watchdog allows several times that.
  initial begin
    #30_000_000;
    $display("FAIL");
    $finish;
  end

  // Presents one word and holds it until the unit takes it. Reading busy right
  // after the edge gives the value that edge saw, which is what decided the
  // handshake. When the next word follows at once, start simply stays high.
  task automatic send_word(input logic [1:0] op, input logic signed [VALUE_W-1:0] key);
    start     <= 1'b1;
    in_opcode <= op;
    in_value  <= key;
    do @(posedge clk); while (busy);
    if (op == OP_INSERT && stored_keys.size() < TABLE_DEPTH) stored_keys.push_back(key);
    words_sent++;
  endtask

  // Drops start for the given number of cycles and puts junk on the payload ports,
  // which the unit must ignore while start is low.
  task automatic idle_for(input int unsigned cycles);
    repeat (cycles) begin
      start     <= 1'b0;
      in_opcode <= 2'($urandom);
      in_value  <= $urandom;
      @(posedge clk);
    end
  endtask

  // Holds off until every predicted result word has come back. The first edge
  // lets the checker count the word that was accepted last.
  task automatic wait_all_replies();
    start <= 1'b0;
    @(posedge clk);
    while (replies_owed != 0) @(posedge clk);
  endtask

  // Keys lean toward values already in the table and their neighbors, so that
  // finds hit, counts see duplicates and inserts land among equal entries.
  function automatic logic signed [VALUE_W-1:0] pick_key();
    int unsigned               sel;
    logic signed [VALUE_W-1:0] base;
    sel = $urandom_range(99);
    if (stored_keys.size() > 0 && sel < 55) begin
      base = stored_keys[$urandom_range(stored_keys.size() - 1)];
      if (sel < 40) return base;
      return (sel < 48) ? base + 1 : base - 1;
    end
    if (sel < 70) return $signed($urandom_range(16)) - 8;
    if (sel < 80) begin
      case ($urandom_range(5))
        0:       return KEY_MIN;
        1:       return KEY_MIN + 1;
        2:       return KEY_MAX;
        3:       return KEY_MAX - 1;
        4:       return '0;
        default: return -1;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [1:0] pick_op();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 38) return OP_INSERT;
    if (sel < 68) return OP_FIND;
    if (sel < 96) return OP_COUNT;
    return OP_SPARE;
  endfunction

  initial begin
    int unsigned idle_pct;
    words_sent = 0;
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_opcode <= OP_INSERT;
    in_value  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Empty table: a find and a count must report nothing, and the spare
    // opcode must return an all-zero word.
    send_word(OP_FIND, KEY_MIN);
    send_word(OP_COUNT, '0);
    send_word(OP_SPARE, KEY_MAX);

    // Inserts at both ends, around zero and repeated, so that later lookups see
    // equal runs and the insert has to land after entries equal to the key.
    send_word(OP_INSERT, '0);
    send_word(OP_INSERT, KEY_MAX);
    send_word(OP_INSERT, KEY_MIN);
    send_word(OP_INSERT, -1);
    send_word(OP_INSERT, '0);
    send_word(OP_INSERT, '0);
    send_word(OP_INSERT, KEY_MIN);
    send_word(OP_INSERT, 1);
    send_word(OP_INSERT, 32'sh5555_5555);
    send_word(OP_INSERT, 32'shAAAA_AAAA);

    // Finds of the first of a run, the ends, and misses in the middle and just
    // below the largest entry.
    send_word(OP_FIND, '0);
    send_word(OP_FIND, KEY_MAX);
    send_word(OP_FIND, KEY_MIN);
    send_word(OP_FIND, 5);
    send_word(OP_FIND, KEY_MAX - 1);

    // Counts of runs, a single entry and an absent value.
    send_word(OP_COUNT, '0);
    send_word(OP_COUNT, KEY_MIN);
    send_word(OP_COUNT, KEY_MAX);
    send_word(OP_COUNT, 7);

    // The spare opcode on a non-empty table must answer with an all-zero word
    // and leave the table unchanged.
    send_word(OP_SPARE, -1);
    send_word(OP_COUNT, -1);
    wait_all_replies();

    // Random part. Idling comes in segments: none, light and heavy, so that
    // gaps fall both while the unit scans and while a result is on the output.
    // The table fills up part way through, after which inserts are refused and
    // every count walks a full table.
    while (words_sent < WORD_COUNT) begin
      case ((words_sent / 120) % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 15;
        default: idle_pct = 45;
      endcase
      if (words_sent >= WORD_COUNT - CALM_TAIL) idle_pct = 0;
      send_word(pick_op(), pick_key());
      if (words_sent % 400 == 0 && words_sent < WORD_COUNT - CALM_TAIL)
        wait_all_replies();
      else if ($urandom_range(99) < idle_pct)
        idle_for($urandom_range(1, 5));
    end

    // Drain, then allow longer than one full scan for any stray result word.
    wait_all_replies();
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
